[src/cnv_pkg.sv]
// Shared constants, codes and types for the multi-kernel convolution block.
// No dependencies; compiled first.
package cnv_pkg;

  localparam int MAX_WIDTH       = 256;
  localparam int MAX_HALF_WINDOW = 3;
  localparam int MAX_KERNELS     = 8;
  localparam int DATA_BITS       = 16;
  localparam int FRAC_BITS       = 8;
  localparam int SIDE            = 2 * MAX_HALF_WINDOW + 1;
  localparam int TAPS            = SIDE * SIDE;
  localparam int LINES           = 2 * MAX_HALF_WINDOW;
  localparam int COL_BITS        = $clog2(MAX_WIDTH);
  localparam int SIZE_BITS       = COL_BITS + 1;
  localparam int KSEL_BITS       = $clog2(MAX_KERNELS);
  localparam int KCNT_BITS       = KSEL_BITS + 1;
  localparam int TAP_BITS        = $clog2(TAPS);
  localparam int SPAN_BITS       = 3;
  localparam int ACT_BITS        = 15;
  localparam int PROD_BITS       = 2 * DATA_BITS;
  localparam int ROW_SUM_BITS    = PROD_BITS + 3;
  localparam int ACC_BITS        = ROW_SUM_BITS + 5;
  localparam int CFG_DATA_BITS   = 9;
  localparam int CFG_IDX_BITS    = 2;
  localparam int QUEUE_DEPTH     = 2;

  // Opcodes of an input transaction
  localparam logic [1:0] OP_WEIGHT   = 2'd0;
  localparam logic [1:0] OP_BIAS     = 2'd1;
  localparam logic [1:0] OP_PIXEL    = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_PADDED_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PADDED_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_WINDOW   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KERNELS       = 2'd3;

  typedef logic signed [DATA_BITS-1:0] sample_t;

  // Weight or bias write towards the back end
  typedef struct packed {
    logic                 weight_we;
    logic                 bias_we;
    logic [KSEL_BITS-1:0] ksel;
    logic [TAP_BITS-1:0]  tap;
    sample_t              value;
  } load_t;

  // One window position to be evaluated for all kernels in use
  typedef struct packed {
    sample_t [TAPS-1:0]   taps;
    logic [SPAN_BITS-1:0] span;
    logic [KCNT_BITS-1:0] nk;
    logic [7:0]           row;
    logic [7:0]           col;
  } job_t;

endpackage

[src/cnv_if.sv]
// Valid/ready channel interfaces for input and result transactions.
// Depends on cnv_pkg.
interface cnv_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         opcode;
  logic [2:0]                         kernel_select;
  logic [2:0]                         tap_row;
  logic [2:0]                         tap_column;
  logic signed [cnv_pkg::DATA_BITS-1:0] data_value;

  modport source (output valid, opcode, kernel_select, tap_row, tap_column, data_value,
                  input ready);
  modport sink   (input valid, opcode, kernel_select, tap_row, tap_column, data_value,
                  output ready);
endinterface

interface cnv_out_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    kernel_index;
  logic [7:0]                    out_row;
  logic [7:0]                    out_column;
  logic [cnv_pkg::ACT_BITS-1:0]  activation;
  logic                          last_of_position;

  modport source (output valid, kernel_index, out_row, out_column, activation,
                  last_of_position, input ready);
  modport sink   (input valid, kernel_index, out_row, out_column, activation,
                  last_of_position, output ready);
endinterface

[src/cnv_front.sv]
// Front end: configuration registers, transaction classification, line buffer,
// sliding window and position counters. Depends on cnv_pkg and cnv_if.
module cnv_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cnv_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [cnv_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  cnv_in_if.sink                             in_if,
  output cnv_pkg::job_t                      job_o,
  output logic                               job_valid_o,
  input  logic                               job_ready_i,
  input  logic                               q_empty_i,
  output cnv_pkg::load_t                     load_o
);

  localparam int LW = cnv_pkg::LINES * cnv_pkg::DATA_BITS;

  logic [cnv_pkg::SIZE_BITS-1:0] width_q, height_q, w_eff, h_eff;
  logic [1:0]                    hw_q, hw_eff;
  logic [3:0]                    nk_q, nk_eff;
  logic [cnv_pkg::SPAN_BITS-1:0] span;

  logic [cnv_pkg::COL_BITS-1:0]  col_q, col_d, row_q, row_d;
  logic [cnv_pkg::SIZE_BITS-1:0] c_inc, r_inc;
  logic                          pos_ok, emit;

  logic                          in_fire, pix_fire, is_load, b_fire, b_free;

  logic                          b_valid_q, b_emit_q;
  cnv_pkg::sample_t              b_val_q;
  logic [cnv_pkg::COL_BITS-1:0]  b_addr_q, b_orow_q, b_ocol_q;
  logic [cnv_pkg::SPAN_BITS-1:0] b_span_q;
  logic [cnv_pkg::KCNT_BITS-1:0] b_nk_q;

  logic [LW-1:0]                 line_mem [cnv_pkg::MAX_WIDTH];
  logic [cnv_pkg::MAX_WIDTH-1:0] line_vld_q;
  logic [LW-1:0]                 line_rd_q, fwd_data_q, line_word, line_wdata;
  logic                          line_rd_vld_q, fwd_hit_q, line_we;

  cnv_pkg::sample_t              win_q [cnv_pkg::SIDE][cnv_pkg::SIDE];
  cnv_pkg::sample_t              nwin  [cnv_pkg::SIDE][cnv_pkg::SIDE];
  cnv_pkg::sample_t              col_v [cnv_pkg::SIDE];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd3;
      height_q <= 9'd3;
      hw_q     <= 2'd1;
      nk_q     <= 4'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cnv_pkg::CFG_PADDED_WIDTH:  width_q  <= cfg_data_i;
        cnv_pkg::CFG_PADDED_HEIGHT: height_q <= cfg_data_i;
        cnv_pkg::CFG_HALF_WINDOW:   hw_q     <= cfg_data_i[1:0];
        cnv_pkg::CFG_KERNELS:       nk_q     <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Clamp register values into their working ranges
  always_comb begin
    if (width_q == '0) w_eff = 9'd1;
    else if (width_q > 9'(cnv_pkg::MAX_WIDTH)) w_eff = 9'(cnv_pkg::MAX_WIDTH);
    else w_eff = width_q;
    if (height_q == '0) h_eff = 9'd1;
    else if (height_q > 9'(cnv_pkg::MAX_WIDTH)) h_eff = 9'(cnv_pkg::MAX_WIDTH);
    else h_eff = height_q;
    hw_eff = (hw_q > 2'(cnv_pkg::MAX_HALF_WINDOW)) ? 2'(cnv_pkg::MAX_HALF_WINDOW) : hw_q;
    nk_eff = (nk_q > 4'(cnv_pkg::MAX_KERNELS)) ? 4'(cnv_pkg::MAX_KERNELS) : nk_q;
    span   = {hw_eff, 1'b0};
  end

  // Classify and accept transactions
  assign is_load  = (in_if.opcode == cnv_pkg::OP_WEIGHT) || (in_if.opcode == cnv_pkg::OP_BIAS);
  assign b_fire   = b_valid_q && (!b_emit_q || job_ready_i);
  assign b_free   = !b_valid_q || b_fire;
  assign in_if.ready = is_load ? (!b_valid_q && q_empty_i) : b_free;
  assign in_fire  = in_if.valid && in_if.ready;
  assign pix_fire = in_fire && (in_if.opcode == cnv_pkg::OP_PIXEL);

  // Weight and bias writes go straight to the back end
  always_comb begin
    load_o.weight_we = in_fire && (in_if.opcode == cnv_pkg::OP_WEIGHT) &&
                       (in_if.tap_row < 3'(cnv_pkg::SIDE)) &&
                       (in_if.tap_column < 3'(cnv_pkg::SIDE));
    load_o.bias_we   = in_fire && (in_if.opcode == cnv_pkg::OP_BIAS);
    load_o.ksel      = in_if.kernel_select;
    load_o.tap       = cnv_pkg::TAP_BITS'(in_if.tap_row * cnv_pkg::SIDE + in_if.tap_column);
    load_o.value     = in_if.data_value;
  end

  // Position counters and emission decision
  always_comb begin
    c_inc  = {1'b0, col_q} + 9'd1;
    r_inc  = {1'b0, row_q} + 9'd1;
    pos_ok = ({1'b0, row_q} < h_eff) && ({1'b0, col_q} < w_eff);
    emit   = pos_ok && (row_q >= 8'(span)) && (col_q >= 8'(span)) && (nk_eff != '0);
    if (c_inc >= w_eff) begin
      col_d = '0;
      row_d = (r_inc >= h_eff) ? '0 : r_inc[7:0];
    end else begin
      col_d = c_inc[7:0];
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      b_valid_q <= 1'b0;
      b_emit_q  <= 1'b0;
    end else begin
      if (pix_fire) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (b_free) begin
        b_valid_q <= pix_fire;
        b_emit_q  <= pix_fire && emit;
      end
    end
  end

  // Pixel stage payload
  always_ff @(posedge clk_i) begin
    if (pix_fire) begin
      b_val_q  <= in_if.data_value;
      b_addr_q <= col_q;
      b_orow_q <= row_q - 8'(span);
      b_ocol_q <= col_q - 8'(span);
      b_span_q <= span;
      b_nk_q   <= nk_eff;
    end
  end

  // Line buffer: one word holds every stored row of a column
  assign line_we = b_fire;

  always_ff @(posedge clk_i) begin
    if (line_we) line_mem[b_addr_q] <= line_wdata;
    if (pix_fire) line_rd_q <= line_mem[col_q];
    if (pix_fire) fwd_data_q <= line_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_vld_q    <= '0;
      line_rd_vld_q <= 1'b0;
      fwd_hit_q     <= 1'b0;
    end else begin
      if (line_we) line_vld_q[b_addr_q] <= 1'b1;
      if (pix_fire) begin
        line_rd_vld_q <= line_vld_q[col_q];
        fwd_hit_q     <= line_we && (b_addr_q == col_q);
      end
    end
  end

  // Build the new window column and the shifted window
  always_comb begin
    if (fwd_hit_q) line_word = fwd_data_q;
    else if (line_rd_vld_q) line_word = line_rd_q;
    else line_word = '0;
    for (int i = 0; i < cnv_pkg::LINES; i++) begin
      col_v[i] = line_word[i*cnv_pkg::DATA_BITS +: cnv_pkg::DATA_BITS];
    end
    col_v[cnv_pkg::SIDE-1] = b_val_q;
    for (int i = 0; i < cnv_pkg::LINES; i++) begin
      line_wdata[i*cnv_pkg::DATA_BITS +: cnv_pkg::DATA_BITS] = col_v[i+1];
    end
    for (int i = 0; i < cnv_pkg::SIDE; i++) begin
      for (int j = 0; j < cnv_pkg::SIDE - 1; j++) begin
        nwin[i][j] = win_q[i][j+1];
      end
      nwin[i][cnv_pkg::SIDE-1] = col_v[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cnv_pkg::SIDE; i++) begin
        for (int j = 0; j < cnv_pkg::SIDE; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (b_fire) begin
      win_q <= nwin;
    end
  end

  // Align the active window to the top-left taps, zero the rest
  always_comb begin
    int base;
    base = cnv_pkg::LINES - int'(b_span_q);
    for (int a = 0; a < cnv_pkg::SIDE; a++) begin
      for (int b = 0; b < cnv_pkg::SIDE; b++) begin
        if (a <= int'(b_span_q) && b <= int'(b_span_q)) begin
          job_o.taps[a*cnv_pkg::SIDE+b] = nwin[base+a][base+b];
        end else begin
          job_o.taps[a*cnv_pkg::SIDE+b] = '0;
        end
      end
    end
    job_o.span = b_span_q;
    job_o.nk   = b_nk_q;
    job_o.row  = b_orow_q;
    job_o.col  = b_ocol_q;
  end

  assign job_valid_o = b_valid_q && b_emit_q;

  a_fwd_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_fire && line_we && (b_addr_q == col_q)) |=> fwd_hit_q)
    else $error("line forward missing after a same-column write");

endmodule

[src/cnv_queue.sv]
// Two-entry queue of window positions between front and back end.
// Depends on cnv_pkg.
module cnv_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cnv_pkg::job_t data_i,
  output logic          full_o,
  output logic          empty_o,
  input  logic          pop_i,
  output cnv_pkg::job_t data_o
);

  localparam int PW = $clog2(cnv_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(cnv_pkg::QUEUE_DEPTH + 1);

  cnv_pkg::job_t  mem_q [cnv_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  count_q;

  assign full_o  = (count_q == CW'(cnv_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == PW'(cnv_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == PW'(cnv_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (push_i && !pop_i) count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

[src/cnv_back.sv]
// Back end (depends on cnv_pkg, cnv_if): weight and bias stores, one kernel
// per cycle unless out_if stalls: multiply, row-sum, total, activation pipeline.
module cnv_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cnv_pkg::load_t load_i,
  input  cnv_pkg::job_t  job_i,
  input  logic           job_valid_i,
  output logic           job_pop_o,
  cnv_out_if.source      out_if
);

  localparam int T  = cnv_pkg::TAPS;
  localparam int S  = cnv_pkg::SIDE;
  localparam int KB = cnv_pkg::KSEL_BITS;

  logic                          en, issue, last;
  logic [KB-1:0]                 k_q;

  // Stage 0: weights read, window and tags held
  logic                          s0_valid_q, s0_last_q;
  logic [KB-1:0]                 s0_k_q;
  logic [7:0]                    s0_row_q, s0_col_q;
  logic [cnv_pkg::SPAN_BITS-1:0] s0_span_q;
  cnv_pkg::sample_t [T-1:0]      s0_win_q;
  cnv_pkg::sample_t              w_rd_q [T];
  cnv_pkg::sample_t              b_rd_q;
  cnv_pkg::sample_t              bmem [cnv_pkg::MAX_KERNELS];

  // Stage 1: products
  logic                          s1_valid_q, s1_last_q;
  logic [KB-1:0]                 s1_k_q;
  logic [7:0]                    s1_row_q, s1_col_q;
  cnv_pkg::sample_t              s1_bias_q;
  logic signed [cnv_pkg::PROD_BITS-1:0] s1_prod_q [T];

  // Stage 2: row sums
  logic                          s2_valid_q, s2_last_q;
  logic [KB-1:0]                 s2_k_q;
  logic [7:0]                    s2_row_q, s2_col_q;
  cnv_pkg::sample_t              s2_bias_q;
  logic signed [cnv_pkg::ROW_SUM_BITS-1:0] rs_d [S];
  logic signed [cnv_pkg::ROW_SUM_BITS-1:0] s2_rs_q [S];

  // Stage 3: total with bias
  logic                          s3_valid_q, s3_last_q;
  logic [KB-1:0]                 s3_k_q;
  logic [7:0]                    s3_row_q, s3_col_q;
  logic signed [cnv_pkg::ACC_BITS-1:0] tot_d, s3_tot_q, rnd;
  logic [cnv_pkg::ACT_BITS-1:0]  act_d;

  // Result register
  logic                          out_valid_q, out_last_q;
  logic [KB-1:0]                 out_k_q;
  logic [7:0]                    out_row_q, out_col_q;
  logic [cnv_pkg::ACT_BITS-1:0]  out_act_q;

  assign en        = !out_valid_q || out_if.ready;
  assign issue     = en && job_valid_i;
  assign last      = ({1'b0, k_q} + 1'b1) == job_i.nk;
  assign job_pop_o = issue && last;

  // Walk the kernels of the queue head
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (issue) begin
      k_q <= last ? '0 : k_q + 1'b1;
    end
  end

  // Weight store: one small memory per tap, indexed by kernel
  for (genvar t = 0; t < T; t++) begin : g_tap
    localparam int A = t / S;
    localparam int B = t % S;
    cnv_pkg::sample_t wmem [cnv_pkg::MAX_KERNELS];
    logic             tap_on;

    always_ff @(posedge clk_i) begin
      if (load_i.weight_we && load_i.tap == cnv_pkg::TAP_BITS'(t)) begin
        wmem[load_i.ksel] <= load_i.value;
      end
      if (issue) w_rd_q[t] <= wmem[k_q];
    end

    assign tap_on = (A <= int'(s0_span_q)) && (B <= int'(s0_span_q));

    // Multiply active taps only
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (tap_on) s1_prod_q[t] <= $signed(s0_win_q[t]) * $signed(w_rd_q[t]);
        else s1_prod_q[t] <= '0;
      end
    end
  end

  // Bias store
  always_ff @(posedge clk_i) begin
    if (load_i.bias_we) bmem[load_i.ksel] <= load_i.value;
    if (issue) b_rd_q <= bmem[k_q];
  end

  // Pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q  <= issue;
      s1_valid_q  <= s0_valid_q;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  // Row sums and total
  always_comb begin
    for (int a = 0; a < S; a++) begin
      rs_d[a] = '0;
      for (int b = 0; b < S; b++) begin
        rs_d[a] = rs_d[a] + cnv_pkg::ROW_SUM_BITS'(s1_prod_q[a*S+b]);
      end
    end
    tot_d = {{(cnv_pkg::ACC_BITS-cnv_pkg::DATA_BITS-cnv_pkg::FRAC_BITS){s2_bias_q[15]}},
             s2_bias_q, {cnv_pkg::FRAC_BITS{1'b0}}};
    for (int a = 0; a < S; a++) begin
      tot_d = tot_d + cnv_pkg::ACC_BITS'(s2_rs_q[a]);
    end
  end

  // Rectify, round to unsigned Q7.8 and saturate
  always_comb begin
    rnd = (s3_tot_q + cnv_pkg::ACC_BITS'(1 << (cnv_pkg::FRAC_BITS - 1))) >>> cnv_pkg::FRAC_BITS;
    if (s3_tot_q <= 0) act_d = '0;
    else if (rnd > cnv_pkg::ACC_BITS'((1 << cnv_pkg::ACT_BITS) - 1)) act_d = '1;
    else act_d = rnd[cnv_pkg::ACT_BITS-1:0];
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (issue) begin
      s0_k_q    <= k_q;
      s0_last_q <= last;
      s0_row_q  <= job_i.row;
      s0_col_q  <= job_i.col;
      s0_span_q <= job_i.span;
      s0_win_q  <= job_i.taps;
    end
    if (en) begin
      s1_k_q    <= s0_k_q;
      s1_last_q <= s0_last_q;
      s1_row_q  <= s0_row_q;
      s1_col_q  <= s0_col_q;
      s1_bias_q <= b_rd_q;
      s2_k_q    <= s1_k_q;
      s2_last_q <= s1_last_q;
      s2_row_q  <= s1_row_q;
      s2_col_q  <= s1_col_q;
      s2_bias_q <= s1_bias_q;
      s2_rs_q   <= rs_d;
      s3_k_q    <= s2_k_q;
      s3_last_q <= s2_last_q;
      s3_row_q  <= s2_row_q;
      s3_col_q  <= s2_col_q;
      s3_tot_q  <= tot_d;
      out_k_q    <= s3_k_q;
      out_last_q <= s3_last_q;
      out_row_q  <= s3_row_q;
      out_col_q  <= s3_col_q;
      out_act_q  <= act_d;
    end
  end

  assign out_if.valid            = out_valid_q;
  assign out_if.kernel_index     = 3'(out_k_q);
  assign out_if.out_row          = out_row_q;
  assign out_if.out_column       = out_col_q;
  assign out_if.activation       = out_act_q;
  assign out_if.last_of_position = out_last_q;

  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> ({1'b0, k_q} < job_i.nk))
    else $error("kernel counter beyond kernels in use");

  a_k_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> (k_q == '0))
    else $error("kernel counter not restarted after position");

endmodule

[src/conv2d_relu_multi_kernel.sv]
// Top level of the multi-kernel convolution block: front end, queue, back end.
// Depends on cnv_pkg, cnv_if, cnv_front, cnv_queue and cnv_back.
//
// A pixel transaction is taken every cycle while the two-entry position queue
// has room; a pixel that completes an interior window occupies the back end
// for one pass per kernel in use (one kernel per cycle while the result
// output is not stalled, through a 49-lane multiply and a registered adder
// tree), so the sustained pixel rate is set by the single result per cycle
// of the back end. Results of a position appear kernel 0 first, with
// last_of_position on the final one. Weight and bias loads are taken only
// when no position is waiting in the queue. The line buffer needs no
// clearing pass after reset.
module conv2d_relu_multi_kernel (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cnv_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [cnv_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  cnv_in_if.sink                             in_if,
  cnv_out_if.source                          out_if
);

  cnv_pkg::job_t  job_push, job_head;
  cnv_pkg::load_t load;
  logic           job_valid, q_full, q_empty, job_pop, push;

  assign push = job_valid && !q_full;

  cnv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_if       (in_if),
    .job_o       (job_push),
    .job_valid_o (job_valid),
    .job_ready_i (!q_full),
    .q_empty_i   (q_empty),
    .load_o      (load)
  );

  cnv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_push),
    .full_o  (q_full),
    .empty_o (q_empty),
    .pop_i   (job_pop),
    .data_o  (job_head)
  );

  cnv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .job_i       (job_head),
    .job_valid_i (!q_empty),
    .job_pop_o   (job_pop),
    .out_if      (out_if)
  );

endmodule
